### src/ovc_pkg.sv
package ovc_pkg;

  localparam int SLOTS       = 8;
  localparam int SLOT_W      = 3;
  localparam int COORD_W     = 11;
  localparam int PIX_W       = 12;
  localparam int SLOT_PIXELS = 4096;
  localparam int AREA_W      = 13;
  localparam int COLOR_W     = 16;
  localparam int ADDR_W      = SLOT_W + PIX_W;

  typedef enum logic [2:0] {
    ACT_COMPOSE = 3'd0,
    ACT_CREATE  = 3'd1,
    ACT_MOVE    = 3'd2,
    ACT_SHOW    = 3'd3,
    ACT_DESTROY = 3'd4,
    ACT_WRITE   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ARG    = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_NO_FREE    = 2'd3
  } status_t;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               create;
    logic               move;
    logic               show;
    logic               destroy;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [AREA_W-1:0]  area;
    logic               visible;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] wide;
  } best_t;

  typedef struct packed {
    logic               in_use;
    logic               first_free;
    logic [COORD_W-1:0] wide;
    logic [COORD_W-1:0] tall;
    logic [AREA_W-1:0]  area;
  } cell_info_t;

endpackage

### src/overlay_plane_compositor_core.sv
// overlay plane compositor
// input channel: in_valid/in_ready with action, slot, pos_x, pos_y, width, height,
// visible, pixel_index and color_in; one item per cycle while in_ready is high.
// output channel: out_valid/out_ready with color_out, covered, status and
// result_slot; exactly one result per input item, in order.
// config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 screen width,
// 1 screen height; write only while the block is idle.
// slot table lives in a row of eight cells; each cell tests its own rectangle
// and passes the topmost hit and the free-slot search to its neighbor.
// from accept to result an item goes through table update and hit select,
// then the offset multiply, then the registered pixel memory read.
// pixel writes go to the memory at the same stage as compose reads so order
// is kept. throughput is one item per cycle while out_ready stays high.
// reset clears the slot table and loads 320 x 240 as screen size; pixel
// memory is not cleared. when out_ready is low while a result is waiting,
// the whole pipe holds and in_ready drops.
module overlay_plane_compositor_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   action,
  input  logic [2:0]                   slot,
  input  logic [10:0]                  pos_x,
  input  logic [10:0]                  pos_y,
  input  logic [10:0]                  width,
  input  logic [10:0]                  height,
  input  logic                         visible,
  input  logic [11:0]                  pixel_index,
  input  logic [15:0]                  color_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  color_out,
  output logic                         covered,
  output logic [1:0]                   status,
  output logic [2:0]                   result_slot,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [10:0]                  cfg_data
);

  logic [10:0] screen_width;
  logic [10:0] screen_height;

  logic                 en;
  logic                 acc;
  ovc_pkg::cmd_t        cmd;
  ovc_pkg::cell_info_t  info [ovc_pkg::SLOTS];
  ovc_pkg::best_t       best [ovc_pkg::SLOTS+1];
  logic                 free [ovc_pkg::SLOTS+1];
  ovc_pkg::cell_info_t  tgt;
  logic [21:0]          prod;
  logic [11:0]          cx;
  logic [11:0]          cy;
  logic [11:0]          mx;
  logic [11:0]          my;
  logic                 create_ok;
  logic                 move_ok;
  logic                 write_ok;
  ovc_pkg::status_t     st;
  logic [2:0]           new_slot;

  // stage 1
  logic                 v1;
  ovc_pkg::status_t     st1;
  logic [2:0]           rs1;
  logic                 cmp1;
  logic                 hit1;
  logic                 wr1;
  logic [2:0]           sl1;
  logic [10:0]          dx1;
  logic [10:0]          dy1;
  logic [10:0]          wd1;
  logic [11:0]          pi1;
  logic [15:0]          col1;
  // stage 2
  logic                 v2;
  ovc_pkg::status_t     st2;
  logic [2:0]           rs2;
  logic                 cmp2;
  logic                 hit2;
  logic                 wr2;
  logic [14:0]          addr2;
  logic [15:0]          col2;
  logic [21:0]          off;
  // stage 3
  logic                 v3;
  ovc_pkg::status_t     st3;
  logic [2:0]           rs3;
  logic                 cmp3;
  logic                 hit3;
  logic [15:0]          col3;
  logic [15:0]          rdata;

  assign en        = !v3 || out_ready;
  assign in_ready  = en;
  assign acc       = in_valid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 11'd320;
      screen_height <= 11'd240;
    end else if (cfg_valid) begin
      unique case (ovc_pkg::cfg_reg_t'(cfg_index))
        ovc_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        ovc_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
      endcase
    end
  end

  assign tgt  = info[slot];
  assign prod = {11'd0, width} * {11'd0, height};
  assign cx   = {1'b0, pos_x} + {1'b0, width};
  assign cy   = {1'b0, pos_y} + {1'b0, height};
  assign mx   = {1'b0, pos_x} + {1'b0, tgt.wide};
  assign my   = {1'b0, pos_y} + {1'b0, tgt.tall};

  always_comb begin
    create_ok = (width != '0) && (height != '0)
                && (prod <= 22'(ovc_pkg::SLOT_PIXELS))
                && (cx <= {1'b0, screen_width}) && (cy <= {1'b0, screen_height});
    move_ok   = (mx <= {1'b0, screen_width}) && (my <= {1'b0, screen_height});
    write_ok  = {1'b0, pixel_index} < tgt.area;
    new_slot  = '0;
    for (int i = ovc_pkg::SLOTS - 1; i >= 0; i--) begin
      if (info[i].first_free) begin
        new_slot = 3'(i);
      end
    end
    st = ovc_pkg::ST_OK;
    unique case (action)
      ovc_pkg::ACT_COMPOSE: st = ovc_pkg::ST_OK;
      ovc_pkg::ACT_CREATE: begin
        if (!create_ok) begin
          st = ovc_pkg::ST_BAD_ARG;
        end else if (!free[ovc_pkg::SLOTS]) begin
          st = ovc_pkg::ST_NO_FREE;
        end
      end
      ovc_pkg::ACT_MOVE, ovc_pkg::ACT_SHOW, ovc_pkg::ACT_DESTROY,
      ovc_pkg::ACT_WRITE: begin
        if (!tgt.in_use) begin
          st = ovc_pkg::ST_NOT_IN_USE;
        end else if (action == ovc_pkg::ACT_MOVE && !move_ok) begin
          st = ovc_pkg::ST_BAD_ARG;
        end else if (action == ovc_pkg::ACT_WRITE && !write_ok) begin
          st = ovc_pkg::ST_BAD_ARG;
        end
      end
      default: st = ovc_pkg::ST_BAD_ARG;
    endcase
  end

  always_comb begin
    cmd.create  = acc && action == ovc_pkg::ACT_CREATE && st == ovc_pkg::ST_OK;
    cmd.move    = acc && action == ovc_pkg::ACT_MOVE && st == ovc_pkg::ST_OK;
    cmd.show    = acc && action == ovc_pkg::ACT_SHOW && st == ovc_pkg::ST_OK;
    cmd.destroy = acc && action == ovc_pkg::ACT_DESTROY && st == ovc_pkg::ST_OK;
    cmd.slot    = slot;
    cmd.x       = pos_x;
    cmd.y       = pos_y;
    cmd.w       = width;
    cmd.h       = height;
    cmd.area    = prod[ovc_pkg::AREA_W-1:0];
    cmd.visible = visible;
  end

  assign best[0] = '0;
  assign free[0] = 1'b0;

  for (genvar g = 0; g < ovc_pkg::SLOTS; g++) begin : g_cell
    ovc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .id       (3'(g)),
      .cmd      (cmd),
      .px       (pos_x),
      .py       (pos_y),
      .free_in  (free[g]),
      .free_out (free[g+1]),
      .best_in  (best[g]),
      .best_out (best[g+1]),
      .info     (info[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1  <= st;
      rs1  <= cmd.create ? new_slot : 3'd0;
      cmp1 <= action == ovc_pkg::ACT_COMPOSE;
      hit1 <= best[ovc_pkg::SLOTS].hit;
      wr1  <= in_valid && action == ovc_pkg::ACT_WRITE && st == ovc_pkg::ST_OK;
      sl1  <= (action == ovc_pkg::ACT_COMPOSE) ? best[ovc_pkg::SLOTS].slot : slot;
      dx1  <= best[ovc_pkg::SLOTS].dx;
      dy1  <= best[ovc_pkg::SLOTS].dy;
      wd1  <= best[ovc_pkg::SLOTS].wide;
      pi1  <= pixel_index;
      col1 <= color_in;

      st2   <= st1;
      rs2   <= rs1;
      cmp2  <= cmp1;
      hit2  <= cmp1 && hit1;
      wr2   <= v1 && wr1;
      addr2 <= {sl1, (cmp1 ? off[11:0] : pi1)};
      col2  <= col1;

      st3  <= st2;
      rs3  <= rs2;
      cmp3 <= cmp2;
      hit3 <= hit2;
      col3 <= col2;
    end
  end

  assign off = {11'd0, dy1} * {11'd0, wd1} + {11'd0, dx1};

  ovc_ram #(
    .WIDTH (ovc_pkg::COLOR_W),
    .DEPTH (ovc_pkg::SLOTS * ovc_pkg::SLOT_PIXELS)
  ) u_pixels (
    .clk   (clk),
    .we    (en && wr2),
    .waddr (addr2),
    .wdata (col2),
    .re    (en && hit2),
    .raddr (addr2),
    .rdata (rdata)
  );

  assign out_valid   = v3;
  assign covered     = hit3;
  assign status      = st3;
  assign result_slot = rs3;
  assign color_out   = hit3 ? rdata : (cmp3 ? col3 : 16'd0);

endmodule

### src/ovc_ram.sv
module ovc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/ovc_cell.sv
module ovc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ovc_pkg::SLOT_W-1:0]    id,
  input  ovc_pkg::cmd_t                 cmd,
  input  logic [ovc_pkg::COORD_W-1:0]   px,
  input  logic [ovc_pkg::COORD_W-1:0]   py,
  input  logic                          free_in,
  output logic                          free_out,
  input  ovc_pkg::best_t                best_in,
  output ovc_pkg::best_t                best_out,
  output ovc_pkg::cell_info_t           info
);

  logic                          in_use;
  logic                          shown;
  logic [ovc_pkg::COORD_W-1:0]   left;
  logic [ovc_pkg::COORD_W-1:0]   top;
  logic [ovc_pkg::COORD_W-1:0]   wide;
  logic [ovc_pkg::COORD_W-1:0]   tall;
  logic [ovc_pkg::AREA_W-1:0]    area;
  logic                          first_free;
  logic                          mine;
  logic [ovc_pkg::COORD_W:0]     right;
  logic [ovc_pkg::COORD_W:0]     bottom;
  logic                          hit;

  assign first_free = !free_in && !in_use;
  assign free_out   = free_in || !in_use;
  assign mine       = (cmd.slot == id);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
      shown  <= 1'b0;
    end else if (cmd.create && first_free) begin
      in_use <= 1'b1;
      shown  <= 1'b0;
    end else if (cmd.destroy && mine) begin
      in_use <= 1'b0;
      shown  <= 1'b0;
    end else if (cmd.show && mine) begin
      shown <= cmd.visible;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      top  <= '0;
      wide <= '0;
      tall <= '0;
      area <= '0;
    end else if (cmd.create && first_free) begin
      left <= cmd.x;
      top  <= cmd.y;
      wide <= cmd.w;
      tall <= cmd.h;
      area <= cmd.area;
    end else if (cmd.move && mine) begin
      left <= cmd.x;
      top  <= cmd.y;
    end
  end

  always_comb begin
    right  = {1'b0, left} + {1'b0, wide};
    bottom = {1'b0, top} + {1'b0, tall};
    hit    = in_use && shown && (px >= left) && ({1'b0, px} < right)
             && (py >= top) && ({1'b0, py} < bottom);
    if (hit) begin
      best_out.hit  = 1'b1;
      best_out.slot = id;
      best_out.dx   = px - left;
      best_out.dy   = py - top;
      best_out.wide = wide;
    end else begin
      best_out = best_in;
    end
  end

  assign info.in_use     = in_use;
  assign info.first_free = first_free;
  assign info.wide       = wide;
  assign info.tall       = tall;
  assign info.area       = area;

endmodule
